[hw/rtl/jlcs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jlcs_pkg: shared types and constants of the command smoother
// Holds the serial multiply/divide request and response types, the state
// machine encodings and the configuration register map.
// ----------------------------------------------------------------------------
package jlcs_pkg;

    // operand, product and step counter widths of the serial unit
    localparam int unsigned DW    = 20;
    localparam int unsigned PW    = 40;
    localparam int unsigned CNT_W = 6;

    localparam logic [CNT_W-1:0] MUL_LAST = 6'd19;
    localparam logic [CNT_W-1:0] DIV_LAST = 6'd39;

    localparam logic [DW-1:0] US_PER_S = 20'd1000000;

    // configuration register map
    localparam logic [2:0] REG_MIN_STEP   = 3'd0;
    localparam logic [2:0] REG_MAX_STEP   = 3'd1;
    localparam logic [2:0] REG_MAX_DECEL  = 3'd2;
    localparam logic [2:0] REG_MAX_ACCEL  = 3'd3;
    localparam logic [2:0] REG_MAX_JERK   = 3'd4;
    localparam logic [2:0] REG_FRONT_RATE = 3'd5;
    localparam logic [2:0] REG_REAR_RATE  = 3'd6;

    // register reset values
    localparam logic [19:0] MIN_STEP_RST   = 20'd1000;
    localparam logic [19:0] MAX_STEP_RST   = 20'd100000;
    localparam logic [14:0] MAX_DECEL_RST  = 15'd3072;
    localparam logic [14:0] MAX_ACCEL_RST  = 15'd2048;
    localparam logic [19:0] MAX_JERK_RST   = 20'd4096;
    localparam logic [15:0] STEER_RATE_RST = 16'd8192;

    localparam logic [7:0] BRAKE_FULL   = 8'hFF;
    localparam logic [5:0] FLAGS_BYPASS = 6'b000001;

    typedef enum logic [1:0] {
        MD_IDLE,
        MD_MUL,
        MD_DIV,
        MD_DONE
    } md_state_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_WAIT,
        ST_LIMIT,
        ST_FINISH
    } seq_state_t;

    // products and quotients in issue order
    typedef enum logic [2:0] {
        OP_ACC,
        OP_DEC,
        OP_NUM,
        OP_QUO,
        OP_JRK,
        OP_FRT,
        OP_RER,
        OP_VEL
    } op_t;

    typedef struct packed {
        logic          start;
        logic          div_en;
        logic [DW-1:0] a;
        logic [DW-1:0] b;
        logic [DW-1:0] c;
    } md_req_t;

    typedef struct packed {
        logic          done;
        logic [PW-1:0] result;
    } md_rsp_t;

endpackage

[hw/rtl/jlcs_muldiv.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jlcs_muldiv: bit-serial multiply, then optional restoring divide
// Computes a*b (one multiplier bit per step) and, when asked,
// floor(a*b/c) (one quotient bit per step).
// ----------------------------------------------------------------------------
module jlcs_muldiv (
    input  logic              aclk,
    input  logic              aresetn,
    input  jlcs_pkg::md_req_t req,
    output jlcs_pkg::md_rsp_t rsp
);
    import jlcs_pkg::*;

    md_state_t        state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [PW-1:0]    prod_reg, prod_next;
    logic [DW:0]      rem_reg, rem_next;
    logic [DW-1:0]    a_reg;
    logic [DW-1:0]    c_reg;
    logic             div_reg;
    logic [DW:0]      mul_sum;
    logic [DW:0]      rem_shift;
    logic             rem_ge;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            MD_IDLE: if (req.start) state_next = MD_MUL;
            MD_MUL: begin
                if (count_reg == MUL_LAST) state_next = div_reg ? MD_DIV : MD_DONE;
            end
            MD_DIV: if (count_reg == DIV_LAST) state_next = MD_DONE;
            MD_DONE: state_next = MD_IDLE;
            default: state_next = MD_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        rsp.done   = (state_reg == MD_DONE);
        rsp.result = prod_reg;
    end

    // shift-add and shift-subtract steps
    always_comb begin
        count_next = count_reg;
        prod_next  = prod_reg;
        rem_next   = rem_reg;
        mul_sum    = {1'b0, prod_reg[PW-1:DW]} + (prod_reg[0] ? {1'b0, a_reg} : '0);
        rem_shift  = {rem_reg[DW-1:0], prod_reg[PW-1]};
        rem_ge     = (rem_shift >= {1'b0, c_reg});
        case (state_reg)
            MD_IDLE: begin
                if (req.start) begin
                    prod_next  = {{(PW-DW){1'b0}}, req.b};
                    rem_next   = '0;
                    count_next = '0;
                end
            end
            MD_MUL: begin
                prod_next  = {mul_sum, prod_reg[DW-1:1]};
                count_next = (count_reg == MUL_LAST) ? '0 : count_reg + CNT_W'(1);
            end
            MD_DIV: begin
                rem_next   = rem_ge ? rem_shift - {1'b0, c_reg} : rem_shift;
                prod_next  = {prod_reg[PW-2:0], rem_ge};
                count_next = count_reg + CNT_W'(1);
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= MD_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    // hold operands for the whole operation
    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
        rem_reg  <= rem_next;
        if (state_reg == MD_IDLE && req.start) begin
            a_reg   <= req.a;
            c_reg   <= req.c;
            div_reg <= req.div_en;
        end
    end

    a_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        req.start |-> state_reg == MD_IDLE)
        else $error("multiply started while busy");

    a_start_mul: assert property (@(posedge aclk) disable iff (!aresetn)
        req.start |=> state_reg == MD_MUL)
        else $error("start did not enter multiply phase");

    a_done_pulse: assert property (@(posedge aclk) disable iff (!aresetn)
        rsp.done |=> !rsp.done)
        else $error("done held for more than one cycle");

endmodule

[hw/rtl/jerk_limited_command_smoother.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jerk_limited_command_smoother: jerk limited speed and steering smoother
// Turns one target command per control tick into a smoothed speed,
// acceleration and rate limited steering angles.
// ----------------------------------------------------------------------------
// Usage:
//   Input words arrive on s_valid/s_ready, results leave on m_valid/m_ready,
//   one result word per input word, in order. Limits are written through
//   cfg_we/cfg_index/cfg_wdata while no word is in flight.
//   A normal word runs eight products through one bit-serial
//   multiply/divide unit, some with the divide and some without. A
//   stop, brake or disable word bypasses the unit and goes from idle
//   straight to the final step, where the output register is loaded.
//   A new word is not taken while the previous one is still in work.
//   The next word is taken once the previous result sits in the output
//   register, so a stalled receiver holds at most one result and the
//   following word waits in its final step until the register frees.
//   Reset loads the default limits and clears speed, acceleration and
//   steering history to zero; no result is pending after reset.
// ----------------------------------------------------------------------------
module jerk_limited_command_smoother (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [19:0]        cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic signed [15:0] s_target_speed,
    input  logic signed [15:0] s_target_front_steer,
    input  logic signed [15:0] s_target_rear_steer,
    input  logic signed [15:0] s_target_curvature,
    input  logic               s_emergency_stop,
    input  logic [7:0]         s_brake_request,
    input  logic               s_enable,
    input  logic [19:0]        s_elapsed_time,
    output logic               m_valid,
    input  logic               m_ready,
    output logic signed [15:0] m_out_speed,
    output logic signed [15:0] m_out_accel,
    output logic signed [15:0] m_out_front_steer,
    output logic signed [15:0] m_out_rear_steer,
    output logic signed [15:0] m_out_curvature,
    output logic [7:0]         m_out_brake,
    output logic [19:0]        m_applied_step_time,
    output logic [5:0]         m_limit_flags
);
    import jlcs_pkg::*;

    // configuration
    logic [19:0] min_step_reg, max_step_reg, max_jerk_reg;
    logic [14:0] max_decel_reg, max_accel_reg;
    logic [15:0] front_rate_reg, rear_rate_reg;

    // accepted word
    logic [15:0] tgt_speed_reg, tgt_front_reg, tgt_rear_reg, curv_reg;
    logic [7:0]  brake_reg;
    logic [19:0] elapsed_reg;
    logic        bypass_reg;

    // history
    logic [15:0] last_speed_reg, last_accel_reg, last_front_reg, last_rear_reg;

    // sequencer
    seq_state_t state_reg, state_next;
    op_t        op_reg;
    md_req_t    md_req;
    md_rsp_t    md_rsp;

    // serial unit results
    logic [34:0] pa_reg, pd_reg;
    logic [35:0] num_reg, q_reg;
    logic [20:0] jstep_reg;
    logic [16:0] fstep_reg, rstep_reg, vmag_reg;
    logic [15:0] az_reg;
    logic        accel_flag_reg, jerk_flag_reg;

    // output register
    logic        m_valid_reg;
    logic [15:0] m_speed_reg, m_accel_reg, m_front_reg, m_rear_reg, m_curv_reg;
    logic [7:0]  m_brake_reg;
    logic [19:0] m_step_reg;
    logic [5:0]  m_flags_reg;

    logic s_accept, bypass_in, out_free, load_out;

    assign s_accept  = s_valid && s_ready;
    assign bypass_in = s_emergency_stop || (s_brake_request != 8'd0) || !s_enable;
    assign out_free  = !m_valid_reg || m_ready;
    assign load_out  = (state_reg == ST_FINISH) && out_free;

    // ------------------------------------------------------------------
    // step time clamp
    // ------------------------------------------------------------------
    logic [19:0] d0, d1, d_time;
    logic        time_flag;

    always_comb begin
        d0 = (elapsed_reg == 20'd0) ? min_step_reg : elapsed_reg;
        if (d0 < min_step_reg) d1 = min_step_reg;
        else if (d0 > max_step_reg) d1 = max_step_reg;
        else d1 = d0;
        d_time    = (d1 == 20'd0) ? 20'd1 : d1;
        time_flag = (elapsed_reg == 20'd0) || (d_time != elapsed_reg);
    end

    // ------------------------------------------------------------------
    // speed error
    // ------------------------------------------------------------------
    logic signed [16:0] delta;
    logic [16:0]        delta_abs;
    logic               delta_neg, delta_pos;

    always_comb begin
        delta     = $signed({tgt_speed_reg[15], tgt_speed_reg})
                  - $signed({last_speed_reg[15], last_speed_reg});
        delta_neg = delta[16];
        delta_pos = !delta[16] && (delta != 17'sd0);
        delta_abs = delta_neg ? 17'(-delta) : 17'(delta);
    end

    // ------------------------------------------------------------------
    // acceleration and jerk limit
    // ------------------------------------------------------------------
    logic               acc_over, dec_over;
    logic signed [16:0] accel0;
    logic signed [22:0] a23, l23, diff23, js23, cd23, jl23;
    logic               zero_acc;
    logic [15:0]        az;
    logic [16:0]        az_abs;

    always_comb begin
        acc_over = delta_pos && (num_reg > {1'b0, pa_reg});
        dec_over = delta_neg && (num_reg > {1'b0, pd_reg});
        if (acc_over) accel0 = $signed({2'b00, max_accel_reg});
        else if (dec_over) accel0 = -$signed({2'b00, max_decel_reg});
        else if (delta_neg) accel0 = -$signed({1'b0, q_reg[15:0]});
        else accel0 = $signed({1'b0, q_reg[15:0]});
        a23    = $signed({{6{accel0[16]}}, accel0});
        l23    = $signed({{7{last_accel_reg[15]}}, last_accel_reg});
        diff23 = a23 - l23;
        js23   = $signed({2'b00, jstep_reg});
        if (diff23 > js23) cd23 = js23;
        else if (diff23 < -js23) cd23 = -js23;
        else cd23 = diff23;
        jl23     = l23 + cd23;
        zero_acc = (delta_pos && jl23 < 23'sd0) || (delta_neg && jl23 > 23'sd0);
        az       = zero_acc ? 16'd0 : jl23[15:0];
        az_abs   = az_reg[15] ? 17'(-$signed({az_reg[15], az_reg})) : {1'b0, az_reg};
    end

    // ------------------------------------------------------------------
    // speed update, overshoot snap and steering
    // ------------------------------------------------------------------
    logic signed [17:0] vstep;
    logic signed [18:0] next19, tgt19;
    logic               overshoot;
    logic [15:0]        fin_speed, fin_accel, fin_front, fin_rear;

    function automatic logic [15:0] steer_step(input logic [15:0] tgt,
                                               input logic [15:0] last,
                                               input logic [16:0] lim);
        logic signed [17:0] diff;
        logic signed [17:0] lims;
        logic signed [17:0] step;
        logic signed [17:0] sum;
        diff = $signed({{2{tgt[15]}}, tgt}) - $signed({{2{last[15]}}, last});
        lims = $signed({1'b0, lim});
        if (diff > lims) step = lims;
        else if (diff < -lims) step = -lims;
        else step = diff;
        sum = $signed({{2{last[15]}}, last}) + step;
        return sum[15:0];
    endfunction

    always_comb begin
        vstep     = az_reg[15] ? -$signed({1'b0, vmag_reg}) : $signed({1'b0, vmag_reg});
        next19    = $signed({{3{last_speed_reg[15]}}, last_speed_reg})
                  + $signed({vstep[17], vstep});
        tgt19     = $signed({{3{tgt_speed_reg[15]}}, tgt_speed_reg});
        overshoot = (!delta_neg && next19 > tgt19) || (delta_neg && next19 < tgt19);
        if (overshoot) begin
            fin_speed = tgt_speed_reg;
            if (!delta_neg) fin_accel = (q_reg > 36'd32767) ? 16'h7FFF : q_reg[15:0];
            else fin_accel = (q_reg > 36'd32768) ? 16'h8000 : 16'(-q_reg[15:0]);
        end else begin
            fin_accel = az_reg;
            if (next19 > 19'sd32767) fin_speed = 16'h7FFF;
            else if (next19 < -19'sd32768) fin_speed = 16'h8000;
            else fin_speed = next19[15:0];
        end
        fin_front = steer_step(tgt_front_reg, last_front_reg, fstep_reg);
        fin_rear  = steer_step(tgt_rear_reg, last_rear_reg, rstep_reg);
    end

    // ------------------------------------------------------------------
    // sequencer: next state
    // ------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (s_valid) state_next = bypass_in ? ST_FINISH : ST_START;
            ST_START: state_next = ST_WAIT;
            ST_WAIT: begin
                if (md_rsp.done) begin
                    if (op_reg == OP_RER) state_next = ST_LIMIT;
                    else if (op_reg == OP_VEL) state_next = ST_FINISH;
                    else state_next = ST_START;
                end
            end
            ST_LIMIT:  state_next = ST_START;
            ST_FINISH: if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // sequencer: outputs and operand select
    // ------------------------------------------------------------------
    always_comb begin
        s_ready       = (state_reg == ST_IDLE);
        md_req.start  = (state_reg == ST_START);
        md_req.div_en = 1'b1;
        md_req.b      = d_time;
        md_req.c      = US_PER_S;
        md_req.a      = '0;
        unique case (op_reg)
            OP_ACC: begin
                md_req.a      = {5'd0, max_accel_reg};
                md_req.div_en = 1'b0;
            end
            OP_DEC: begin
                md_req.a      = {5'd0, max_decel_reg};
                md_req.div_en = 1'b0;
            end
            OP_NUM: begin
                md_req.a      = {4'd0, delta_abs[15:0]};
                md_req.b      = US_PER_S;
                md_req.div_en = 1'b0;
            end
            OP_QUO: begin
                md_req.a = {4'd0, delta_abs[15:0]};
                md_req.b = US_PER_S;
                md_req.c = d_time;
            end
            OP_JRK:  md_req.a = max_jerk_reg;
            OP_FRT:  md_req.a = {4'd0, front_rate_reg};
            OP_RER:  md_req.a = {4'd0, rear_rate_reg};
            OP_VEL:  md_req.a = {4'd0, az_abs[15:0]};
            default: md_req.a = '0;
        endcase
    end

    jlcs_muldiv u_muldiv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (md_req),
        .rsp     (md_rsp)
    );

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    // write configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_step_reg   <= MIN_STEP_RST;
            max_step_reg   <= MAX_STEP_RST;
            max_decel_reg  <= MAX_DECEL_RST;
            max_accel_reg  <= MAX_ACCEL_RST;
            max_jerk_reg   <= MAX_JERK_RST;
            front_rate_reg <= STEER_RATE_RST;
            rear_rate_reg  <= STEER_RATE_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_MIN_STEP:   min_step_reg   <= cfg_wdata;
                REG_MAX_STEP:   max_step_reg   <= cfg_wdata;
                REG_MAX_DECEL:  max_decel_reg  <= cfg_wdata[14:0];
                REG_MAX_ACCEL:  max_accel_reg  <= cfg_wdata[14:0];
                REG_MAX_JERK:   max_jerk_reg   <= cfg_wdata;
                REG_FRONT_RATE: front_rate_reg <= cfg_wdata[15:0];
                REG_REAR_RATE:  rear_rate_reg  <= cfg_wdata[15:0];
                default: ;
            endcase
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            m_valid_reg    <= 1'b0;
            last_speed_reg <= '0;
            last_accel_reg <= '0;
            last_front_reg <= '0;
            last_rear_reg  <= '0;
        end else begin
            state_reg <= state_next;
            if (load_out) m_valid_reg <= 1'b1;
            else if (m_ready) m_valid_reg <= 1'b0;
            // advance history, clear it on bypass
            if (load_out) begin
                last_speed_reg <= bypass_reg ? 16'd0 : fin_speed;
                last_accel_reg <= bypass_reg ? 16'd0 : fin_accel;
                last_front_reg <= bypass_reg ? 16'd0 : fin_front;
                last_rear_reg  <= bypass_reg ? 16'd0 : fin_rear;
            end
        end
    end

    // payload and sequencing data
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            tgt_speed_reg <= s_target_speed;
            tgt_front_reg <= s_target_front_steer;
            tgt_rear_reg  <= s_target_rear_steer;
            curv_reg      <= s_target_curvature;
            brake_reg     <= s_brake_request;
            elapsed_reg   <= s_elapsed_time;
            bypass_reg    <= bypass_in;
            op_reg        <= OP_ACC;
        end
        // capture serial results
        if (state_reg == ST_WAIT && md_rsp.done) begin
            case (op_reg)
                OP_ACC:  pa_reg    <= md_rsp.result[34:0];
                OP_DEC:  pd_reg    <= md_rsp.result[34:0];
                OP_NUM:  num_reg   <= md_rsp.result[35:0];
                OP_QUO:  q_reg     <= md_rsp.result[35:0];
                OP_JRK:  jstep_reg <= md_rsp.result[20:0];
                OP_FRT:  fstep_reg <= md_rsp.result[16:0];
                OP_RER:  rstep_reg <= md_rsp.result[16:0];
                OP_VEL:  vmag_reg  <= md_rsp.result[16:0];
                default: ;
            endcase
            if (op_reg != OP_RER && op_reg != OP_VEL) op_reg <= op_t'(op_reg + 3'd1);
        end
        if (state_reg == ST_LIMIT) begin
            az_reg         <= az;
            accel_flag_reg <= acc_over || dec_over;
            jerk_flag_reg  <= (jl23 != a23);
            op_reg         <= OP_VEL;
        end
        // load result word
        if (load_out) begin
            if (bypass_reg) begin
                m_speed_reg <= '0;
                m_accel_reg <= '0;
                m_front_reg <= '0;
                m_rear_reg  <= '0;
                m_curv_reg  <= '0;
                m_brake_reg <= BRAKE_FULL;
                m_step_reg  <= '0;
                m_flags_reg <= FLAGS_BYPASS;
            end else begin
                m_speed_reg <= fin_speed;
                m_accel_reg <= fin_accel;
                m_front_reg <= fin_front;
                m_rear_reg  <= fin_rear;
                m_curv_reg  <= curv_reg;
                m_brake_reg <= brake_reg;
                m_step_reg  <= d_time;
                m_flags_reg <= {fin_rear != tgt_rear_reg, fin_front != tgt_front_reg,
                                jerk_flag_reg, accel_flag_reg, time_flag, 1'b0};
            end
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_out_speed         = m_speed_reg;
    assign m_out_accel         = m_accel_reg;
    assign m_out_front_steer   = m_front_reg;
    assign m_out_rear_steer    = m_rear_reg;
    assign m_out_curvature     = m_curv_reg;
    assign m_out_brake         = m_brake_reg;
    assign m_applied_step_time = m_step_reg;
    assign m_limit_flags       = m_flags_reg;

    a_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> !s_ready)
        else $error("second word accepted while one is in flight");

    a_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        md_rsp.done |-> state_reg == ST_WAIT)
        else $error("serial result arrived outside wait state");

    a_bypass_word: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_limit_flags[0] |-> m_out_brake == BRAKE_FULL
            && m_applied_step_time == 20'd0)
        else $error("bypass word without full brake");

endmodule
